### src/pts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MAX_TASKS = 8;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int TGT_W     = (IDX_W > 3) ? IDX_W : 3;

   typedef enum logic [2:0] {
      CMD_CREATE   = 3'd0,
      CMD_DELAY    = 3'd1,
      CMD_SUSPEND  = 3'd2,
      CMD_ACTIVATE = 3'd3,
      CMD_TICK     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_READY     = 2'd0,
      ST_RUNNING   = 2'd1,
      ST_WAITING   = 2'd2,
      ST_SUSPENDED = 2'd3
   } run_state_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT,
      S_DONE
   } fsm_type;

endpackage : pts_pkg
`default_nettype wire

### src/pts_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts channel interfaces
// Command channel into the scheduler and result channel out of it.
// ----------------------------------------------------------------------------
interface pts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [6:0]  task_priority;
   logic        start_suspended;
   logic [31:0] delay_ticks;
   logic [2:0]  target_task;

   modport source (
      output valid, command, task_priority, start_suspended, delay_ticks, target_task,
      input  ready
   );
   modport sink (
      input  valid, command, task_priority, start_suspended, delay_ticks, target_task,
      output ready
   );
endinterface : pts_req_if

interface pts_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  running_task;
   logic        switched;
   logic [2:0]  new_handle;
   logic        create_failed;
   logic [31:0] clock_ticks;

   modport source (
      output valid, running_task, switched, new_handle, create_failed, clock_ticks,
      input  ready
   );
   modport sink (
      input  valid, running_task, switched, new_handle, create_failed, clock_ticks,
      output ready
   );
endinterface : pts_rsp_if
`default_nettype wire

### src/priority_task_scheduler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_task_scheduler_core
// Fixed-priority preemptive task scheduler: task table, tick countdown and
// highest-priority selection through one sequential pass over the table.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        command, task_priority, start_suspended,
//                                    delay_ticks, target_task
//  rsp_chan  out  valid/ready        running_task, switched, new_handle,
//                                    create_failed, clock_ticks
//
//  create, unknown commands and any command on an empty table: idle, then done
//  delay, suspend, activate, tick: idle, scan, commit, done; the scan is paced by the single
//  table read port, one entry per cycle, countdown and compare shared
//  one item in flight; req ready only while idle, result held in an output
//  register until taken
//  reset (synchronous) empties the table, running task 0, tick count 0
// ----------------------------------------------------------------------------
module priority_task_scheduler_core (
   input  wire logic   clock,
   input  wire logic   reset,
   pts_req_if.sink     req_chan,
   pts_rsp_if.source   rsp_chan
);
   import pts_pkg::*;

   // task table
   logic [6:0]    prio_mem  [MAX_TASKS];
   run_state_type state_mem [MAX_TASKS];
   logic [31:0]   wait_mem  [MAX_TASKS];

   logic [IDX_W-1:0] rd_addr;
   logic [6:0]       rd_prio_ff;
   run_state_type    rd_state_ff;
   logic [31:0]      rd_wait_ff;

   logic             prio_we;
   logic [IDX_W-1:0] prio_wa;
   logic [6:0]       prio_wd;
   logic             state_we;
   logic [IDX_W-1:0] state_wa;
   run_state_type    state_wd;
   logic             wait_we;
   logic [IDX_W-1:0] wait_wa;
   logic [31:0]      wait_wd;

   // control
   fsm_type          state_ff, state_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [31:0]      ticks_ff, ticks_in;
   logic [2:0]       target_ff, target_in;
   logic [CNT_W-1:0] task_cnt_ff, task_cnt_in;
   logic [IDX_W-1:0] running_ff, running_in;
   logic [31:0]      clock_ff, clock_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0] proc_idx_ff, proc_idx_in;
   logic             best_vld_ff, best_vld_in;
   logic [6:0]       best_prio_ff, best_prio_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             sw_ff, sw_in;
   logic [2:0]       handle_ff, handle_in;
   logic             failed_ff, failed_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_run_ff, rsp_run_in;
   logic             rsp_sw_ff, rsp_sw_in;
   logic [2:0]       rsp_handle_ff, rsp_handle_in;
   logic             rsp_failed_ff, rsp_failed_in;
   logic [31:0]      rsp_clock_ff, rsp_clock_in;

   // entry update during the pass
   run_state_type    pr_state;
   logic [31:0]      pr_wait;
   logic             pr_write;
   logic             pr_elig;
   logic [CNT_W-1:0] last_cnt;
   logic [IDX_W-1:0] pick;

   always_ff @(posedge clock) begin
      if (prio_we) begin
         prio_mem[prio_wa] <= prio_wd;
      end
      if (state_we) begin
         state_mem[state_wa] <= state_wd;
      end
      if (wait_we) begin
         wait_mem[wait_wa] <= wait_wd;
      end
      rd_prio_ff  <= prio_mem[rd_addr];
      rd_state_ff <= state_mem[rd_addr];
      rd_wait_ff  <= wait_mem[rd_addr];
   end

   // shared entry unit: applies the command and tick countdown to one entry
   always_comb begin
      pr_state = rd_state_ff;
      pr_wait  = rd_wait_ff;
      pr_write = 1'b0;
      case (cmd_ff)
         CMD_DELAY: begin
            if (proc_idx_ff == running_ff) begin
               pr_state = ST_WAITING;
               pr_wait  = ticks_ff;
               pr_write = 1'b1;
            end
         end
         CMD_SUSPEND: begin
            if (proc_idx_ff == running_ff) begin
               pr_state = ST_SUSPENDED;
               pr_write = 1'b1;
            end
         end
         CMD_ACTIVATE: begin
            if (TGT_W'(target_ff) == TGT_W'(proc_idx_ff)) begin
               pr_state = ST_READY;
               pr_write = 1'b1;
            end
         end
         CMD_TICK: begin
            if (rd_state_ff == ST_WAITING) begin
               pr_write = 1'b1;
               // a count of zero or one runs out on this tick
               if (rd_wait_ff[31:1] == 31'd0) begin
                  pr_state = ST_READY;
                  pr_wait  = 32'd0;
               end else begin
                  pr_wait = rd_wait_ff - 32'd1;
               end
            end
         end
         default: begin
            pr_write = 1'b0;
         end
      endcase
      pr_elig = (pr_state == ST_READY) || (pr_state == ST_RUNNING);
   end

   assign last_cnt = task_cnt_ff - CNT_W'(1);
   assign pick     = best_vld_ff ? best_idx_ff : last_cnt[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ticks_in      = ticks_ff;
      target_in     = target_ff;
      task_cnt_in   = task_cnt_ff;
      running_in    = running_ff;
      clock_in      = clock_ff;
      scan_in       = scan_ff;
      proc_vld_in   = proc_vld_ff;
      proc_idx_in   = proc_idx_ff;
      best_vld_in   = best_vld_ff;
      best_prio_in  = best_prio_ff;
      best_idx_in   = best_idx_ff;
      sw_in         = sw_ff;
      handle_in     = handle_ff;
      failed_in     = failed_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_failed_in = rsp_failed_ff;
      rsp_clock_in  = rsp_clock_ff;

      rd_addr  = scan_ff[IDX_W-1:0];
      prio_we  = 1'b0;
      prio_wa  = task_cnt_ff[IDX_W-1:0];
      prio_wd  = req_chan.task_priority;
      state_we = 1'b0;
      state_wa = proc_idx_ff;
      state_wd = pr_state;
      wait_we  = 1'b0;
      wait_wa  = proc_idx_ff;
      wait_wd  = pr_wait;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in      = req_chan.command;
               ticks_in    = req_chan.delay_ticks;
               target_in   = req_chan.target_task;
               sw_in       = 1'b0;
               handle_in   = 3'd0;
               failed_in   = 1'b0;
               scan_in     = '0;
               proc_vld_in = 1'b0;
               best_vld_in = 1'b0;
               state_in    = S_DONE;
               case (req_chan.command)
                  CMD_CREATE: begin
                     if (task_cnt_ff < CNT_W'(MAX_TASKS)) begin
                        prio_we     = 1'b1;
                        state_we    = 1'b1;
                        state_wa    = task_cnt_ff[IDX_W-1:0];
                        state_wd    = req_chan.start_suspended ? ST_SUSPENDED : ST_READY;
                        wait_we     = 1'b1;
                        wait_wa     = task_cnt_ff[IDX_W-1:0];
                        wait_wd     = 32'd0;
                        handle_in   = 3'(task_cnt_ff);
                        task_cnt_in = task_cnt_ff + CNT_W'(1);
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  CMD_DELAY, CMD_SUSPEND, CMD_ACTIVATE, CMD_TICK: begin
                     if (req_chan.command == CMD_TICK) begin
                        clock_in = clock_ff + 32'd1;
                     end
                     if (task_cnt_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read issue runs one entry ahead of the update
            if (scan_ff < task_cnt_ff) begin
               proc_vld_in = 1'b1;
               proc_idx_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else begin
               proc_vld_in = 1'b0;
            end
            if (proc_vld_ff) begin
               state_we = pr_write;
               wait_we  = pr_write;
               // strictly greater keeps the lowest index on a tie
               if (pr_elig && (!best_vld_ff || (rd_prio_ff > best_prio_ff))) begin
                  best_vld_in  = 1'b1;
                  best_prio_in = rd_prio_ff;
                  best_idx_in  = proc_idx_ff;
               end
            end else if (scan_ff == task_cnt_ff) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (pick != running_ff) begin
               running_in = pick;
               state_we   = 1'b1;
               state_wa   = pick;
               state_wd   = ST_RUNNING;
               sw_in      = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_run_in    = 3'(running_ff);
               rsp_sw_in     = sw_ff;
               rsp_handle_in = handle_ff;
               rsp_failed_in = failed_ff;
               rsp_clock_in  = clock_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         task_cnt_ff  <= '0;
         running_ff   <= '0;
         clock_ff     <= 32'd0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         task_cnt_ff  <= task_cnt_in;
         running_ff   <= running_in;
         clock_ff     <= clock_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ticks_ff      <= ticks_in;
      target_ff     <= target_in;
      scan_ff       <= scan_in;
      proc_idx_ff   <= proc_idx_in;
      best_vld_ff   <= best_vld_in;
      best_prio_ff  <= best_prio_in;
      best_idx_ff   <= best_idx_in;
      sw_ff         <= sw_in;
      handle_ff     <= handle_in;
      failed_ff     <= failed_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_failed_ff <= rsp_failed_in;
      rsp_clock_ff  <= rsp_clock_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.running_task  = rsp_run_ff;
   assign rsp_chan.switched      = rsp_sw_ff;
   assign rsp_chan.new_handle    = rsp_handle_ff;
   assign rsp_chan.create_failed = rsp_failed_ff;
   assign rsp_chan.clock_ticks   = rsp_clock_ff;

`ifndef SYNTH
   // while the table is not empty, the running task lies inside its filled part
   a_running_in_table: assert property (@(posedge clock) disable iff (reset)
      (task_cnt_ff != '0) |-> (running_ff < task_cnt_ff))
      else $error("running task outside task table");

   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      task_cnt_ff <= CNT_W'(MAX_TASKS))
      else $error("task count beyond table size");

   // entry updates only happen inside a pass
   a_proc_in_scan: assert property (@(posedge clock) disable iff (reset)
      proc_vld_ff |-> (state_ff == S_SCAN))
      else $error("entry update outside the table pass");

   // the task count moves only on an accepted create
   a_count_on_create: assert property (@(posedge clock) disable iff (reset)
      (task_cnt_ff != $past(task_cnt_ff)) |->
         ($past(state_ff) == S_IDLE && $past(req_chan.valid)
          && $past(req_chan.command) == CMD_CREATE))
      else $error("task count changed without a create transfer");
`endif

endmodule : priority_task_scheduler_core
`default_nettype wire
